// ===== rtl/dfl_pkg.sv =====
package dfl_pkg;

    // Data path widths
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 18;
    localparam int TAPS        = 49;
    localparam int TAP_AW      = $clog2(TAPS);
    localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W       = PROD_W + $clog2(TAPS);
    localparam int FRAC_SHIFT  = COEF_BITS - 1;

    // Decimation factor register
    localparam int INPUT_RATE_HZ = 48000;
    localparam int FACTOR_W      = 5;
    localparam logic [FACTOR_W-1:0] FACTOR_MIN   = FACTOR_W'(1);
    localparam logic [FACTOR_W-1:0] FACTOR_MAX   = FACTOR_W'(16);
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'((INPUT_RATE_HZ + 4000) / 8000);

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;

    // Hamming-windowed sinc, 3400 Hz cutoff at 48 kHz, Q1.17, sums to 2^17
    localparam logic signed [COEF_BITS-1:0] COEF_ROM [TAPS] = '{
        -18'sd132,  -18'sd111,  -18'sd65,   18'sd18,    18'sd148,
         18'sd317,   18'sd492,   18'sd612,  18'sd601,   18'sd388,
        -18'sd66,   -18'sd735,  -18'sd1520, -18'sd2239, -18'sd2657,
        -18'sd2525, -18'sd1634,  18'sd128,  18'sd2733,  18'sd5994,
         18'sd9579,  18'sd13056, 18'sd15966, 18'sd17900, 18'sd18576,
         18'sd17900, 18'sd15966, 18'sd13056, 18'sd9579,  18'sd5994,
         18'sd2733,  18'sd128,  -18'sd1634, -18'sd2525, -18'sd2657,
        -18'sd2239, -18'sd1520, -18'sd735,  -18'sd66,   18'sd388,
         18'sd601,   18'sd612,   18'sd492,  18'sd317,   18'sd148,
         18'sd18,   -18'sd65,   -18'sd111,  -18'sd132
    };

    // One queued sample and whether it completes a decimation period
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          fire;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MAC,
        BK_FLUSH,
        BK_DONE
    } t_back_state;

endpackage

// ===== rtl/dfl_if.sv =====
interface dfl_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [dfl_pkg::SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface dfl_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [dfl_pkg::SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/decimating_fir_lowpass.sv =====
// Channel      Dir  Payload             Beat
// i_samp_in    in   sample_in  s16 Q1.15 valid && ready
// o_samp_out   out  sample_out s16 Q1.15 valid && ready
// i_cfg_we     in   i_cfg_wdata u5       write enable high
//
// A beat enters the queue on a valid && ready handshake. A sample that does not close a
// decimation period only costs the back end a history write; one that does also walks
// the taps (history write, 49 tap reads through the one multiplier, pipeline drain, load).
// Synchronous active-low reset clears factor to 6, phase, history and queue.
// The queue decouples intake from the MAC; the output register holds a result
// while later beats are taken.
module decimating_fir_lowpass #(
    parameter int QUEUE_DEPTH = dfl_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dfl_pkg::FACTOR_W-1:0] i_cfg_wdata,
    dfl_in_if.sink                       i_samp_in,
    dfl_out_if.source                    o_samp_out
);

    logic          w_push_valid, w_push_ready;
    logic          w_pop_valid, w_pop_ready;
    logic          w_flush;
    dfl_pkg::t_job w_push_job, w_pop_job;

    dfl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_samp_in    (i_samp_in),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_job   (w_push_job),
        .o_flush      (w_flush)
    );

    dfl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_flush      (w_flush),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_job    (w_pop_job)
    );

    dfl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_flush     (w_flush),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_job   (w_pop_job),
        .o_samp_out  (o_samp_out)
    );

endmodule

// ===== rtl/dfl_front.sv =====
module dfl_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dfl_pkg::FACTOR_W-1:0]   i_cfg_wdata,
    dfl_in_if.sink                         i_samp_in,
    output logic                           o_push_valid,
    input  logic                           i_push_ready,
    output dfl_pkg::t_job                  o_push_job,
    output logic                           o_flush
);

    logic [dfl_pkg::FACTOR_W-1:0] r_factor, n_factor;
    logic [dfl_pkg::FACTOR_W-1:0] r_phase, n_phase;
    logic [dfl_pkg::FACTOR_W-1:0] w_phase_inc;
    logic                         w_fire;
    logic                         w_accept;

    // Classify the beat: does it close a decimation period
    assign w_phase_inc = r_phase + 1'b1;
    assign w_fire      = (w_phase_inc >= r_factor);
    assign w_accept    = i_samp_in.valid && i_push_ready;

    assign i_samp_in.ready   = i_push_ready;
    assign o_push_valid      = i_samp_in.valid;
    assign o_push_job.sample = i_samp_in.sample_in;
    assign o_push_job.fire   = w_fire;
    assign o_flush           = i_cfg_we;

    // Factor clamp and phase update
    always_comb begin
        n_factor = r_factor;
        n_phase  = r_phase;
        if (i_cfg_we) begin
            if (i_cfg_wdata < dfl_pkg::FACTOR_MIN) begin
                n_factor = dfl_pkg::FACTOR_MIN;
            end else if (i_cfg_wdata > dfl_pkg::FACTOR_MAX) begin
                n_factor = dfl_pkg::FACTOR_MAX;
            end else begin
                n_factor = i_cfg_wdata;
            end
            n_phase = '0;
        end else if (w_accept) begin
            n_phase = w_fire ? '0 : w_phase_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= dfl_pkg::FACTOR_RESET;
            r_phase  <= '0;
        end else begin
            r_factor <= n_factor;
            r_phase  <= n_phase;
        end
    end

endmodule

// ===== rtl/dfl_queue.sv =====
module dfl_queue #(
    parameter int DEPTH = dfl_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_flush,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  dfl_pkg::t_job i_push_job,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output dfl_pkg::t_job o_pop_job
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    dfl_pkg::t_job   r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push, w_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/dfl_back.sv =====
module dfl_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_flush,
    input  logic          i_pop_valid,
    output logic          o_pop_ready,
    input  dfl_pkg::t_job i_pop_job,
    dfl_out_if.source     o_samp_out
);

    localparam int SB   = dfl_pkg::SAMPLE_BITS;
    localparam int AW   = dfl_pkg::TAP_AW;
    localparam int AccW = dfl_pkg::ACC_W;
    localparam int Fs   = dfl_pkg::FRAC_SHIFT;
    localparam int QW   = AccW + 1 - Fs;

    localparam logic signed [AccW:0] RND_HALF =
        {{(AccW + 1 - Fs){1'b0}}, 1'b1, {(Fs - 1){1'b0}}};
    localparam logic signed [QW-1:0] SAT_HI = {{(QW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
    localparam logic signed [QW-1:0] SAT_LO = {{(QW - SB + 1){1'b1}}, {(SB - 1){1'b0}}};

    dfl_pkg::t_back_state r_state, n_state;

    // History ring, one valid bit per entry
    logic signed [SB-1:0]          r_hist [dfl_pkg::TAPS];
    logic [dfl_pkg::TAPS-1:0]      r_hvld;
    logic [AW-1:0]                 r_wptr;

    // MAC pipeline
    logic [AW-1:0]                 r_tap;
    logic [AW-1:0]                 r_raddr;
    logic signed [SB-1:0]          r_rdata;
    logic                          r_rvld_bit;
    logic                          r_s1_vld;
    logic [AW-1:0]                 r_s1_tap;
    logic signed [dfl_pkg::PROD_W-1:0] r_prod;
    logic                          r_s2_vld;
    logic signed [AccW-1:0]        r_acc;

    // Output register
    logic                          r_out_vld;
    logic signed [SB-1:0]          r_out_data;

    // Control decoded from state
    logic                          w_take;
    logic                          w_issue;
    logic                          w_load;
    logic                          w_last_tap;
    logic                          w_drained;
    logic [AW-1:0]                 w_wptr_next;
    logic [AW-1:0]                 w_raddr_prev;
    logic signed [SB-1:0]          w_samp_eff;
    logic signed [AccW:0]          w_rnd;
    logic signed [QW-1:0]          w_q;
    logic signed [SB-1:0]          w_sat;

    assign w_last_tap   = (r_tap == AW'(dfl_pkg::TAPS - 1));
    assign w_drained    = !r_s1_vld && !r_s2_vld;
    assign w_wptr_next  = (r_wptr == AW'(dfl_pkg::TAPS - 1)) ? '0 : r_wptr + 1'b1;
    assign w_raddr_prev = (r_raddr == '0) ? AW'(dfl_pkg::TAPS - 1) : r_raddr - 1'b1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dfl_pkg::BK_IDLE: begin
                if (i_pop_valid && i_pop_job.fire) begin
                    n_state = dfl_pkg::BK_MAC;
                end
            end
            dfl_pkg::BK_MAC: begin
                if (w_last_tap) begin
                    n_state = dfl_pkg::BK_FLUSH;
                end
            end
            dfl_pkg::BK_FLUSH: begin
                if (w_drained) begin
                    n_state = dfl_pkg::BK_DONE;
                end
            end
            dfl_pkg::BK_DONE: begin
                if (!r_out_vld || o_samp_out.ready) begin
                    n_state = dfl_pkg::BK_IDLE;
                end
            end
            default: n_state = dfl_pkg::BK_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_take  = 1'b0;
        w_issue = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            dfl_pkg::BK_IDLE:  w_take  = i_pop_valid;
            dfl_pkg::BK_MAC:   w_issue = 1'b1;
            dfl_pkg::BK_FLUSH: ;
            dfl_pkg::BK_DONE:  w_load  = !r_out_vld || o_samp_out.ready;
            default: ;
        endcase
    end

    assign o_pop_ready = (r_state == dfl_pkg::BK_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_state <= dfl_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // History write and registered read
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_hist[r_wptr] <= i_pop_job.sample;
        end
        r_rdata <= r_hist[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_hvld <= '0;
            r_wptr <= '0;
        end else if (w_take) begin
            r_hvld[r_wptr] <= 1'b1;
            r_wptr         <= w_wptr_next;
        end
    end

    // Tap walk, newest entry first
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_tap   <= '0;
            r_raddr <= r_wptr;
        end else if (w_issue) begin
            r_tap   <= r_tap + 1'b1;
            r_raddr <= w_raddr_prev;
        end
    end

    // Read, multiply, accumulate
    assign w_samp_eff = r_rvld_bit ? r_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rvld_bit <= r_hvld[r_raddr];
        r_s1_tap   <= r_tap;
        r_prod     <= w_samp_eff * dfl_pkg::COEF_ROM[r_s1_tap];
        if (w_take) begin
            r_acc <= '0;
        end else if (r_s2_vld) begin
            r_acc <= r_acc + AccW'(r_prod);
        end
    end

    // Round half up, then saturate
    assign w_rnd = (AccW + 1)'(r_acc) + RND_HALF;
    assign w_q   = w_rnd[AccW:Fs];

    always_comb begin
        if (w_q > SAT_HI) begin
            w_sat = SAT_HI[SB-1:0];
        end else if (w_q < SAT_LO) begin
            w_sat = SAT_LO[SB-1:0];
        end else begin
            w_sat = w_q[SB-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (o_samp_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_sat;
        end
    end

    assign o_samp_out.valid      = r_out_vld;
    assign o_samp_out.sample_out = r_out_data;

endmodule

// ===== test/decimating_fir_lowpass_tb.sv =====
`timescale 1ns / 1ps

module decimating_fir_lowpass_tb;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int SETTLE_CYCLES = 64;
    localparam int TAIL_CYCLES   = 64;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_GAP       = 13;
    localparam longint SAMP_MAX  = (longint'(1) << (dfl_pkg::SAMPLE_BITS - 1)) - 1;
    localparam longint SAMP_MIN  = -SAMP_MAX - 1;

    typedef logic signed [dfl_pkg::SAMPLE_BITS-1:0] t_sample;

    typedef enum bit {
        ENT_SAMPLE,
        ENT_CFG
    } t_entry_kind;

    typedef enum logic [2:0] {
        MODE_UNIFORM,
        MODE_EXTREME,
        MODE_DC,
        MODE_ALIGNED,
        MODE_SMALL
    } t_stim_mode;

    typedef struct {
        t_entry_kind                  kind;
        logic [dfl_pkg::FACTOR_W-1:0] factor;
        t_sample                      sample;
    } t_pending;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         cfg_we;
    logic [dfl_pkg::FACTOR_W-1:0] cfg_wdata;

    dfl_in_if  samp_in_if ();
    dfl_out_if samp_out_if ();

    decimating_fir_lowpass dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_samp_in   (samp_in_if),
        .o_samp_out  (samp_out_if)
    );

    // Pending stimulus and expected filter outputs
    t_pending pending_q [$];
    t_sample  filtered_q [$];

    // Predictor state: history, pointer, phase and factor
    t_sample                      fir_hist [dfl_pkg::TAPS];
    int                           fir_wptr;
    int                           fir_phase;
    logic [dfl_pkg::FACTOR_W-1:0] fir_factor;

    int  cycle_count;
    int  fail_count;
    bit  in_taken;
    bit  in_loaded;
    bit  out_taken;
    bit  in_burst;
    bit  out_burst;
    int  in_gap;
    int  out_gap;
    int  settle_count;

    function automatic void fir_clear();
        for (int k = 0; k < dfl_pkg::TAPS; k++) begin
            fir_hist[k] = '0;
        end
        fir_wptr  = 0;
        fir_phase = 0;
    endfunction

    // Factor write: zero maps to the minimum, anything above 16 saturates
    function automatic void fir_load_factor(input logic [dfl_pkg::FACTOR_W-1:0] value);
        if (value < dfl_pkg::FACTOR_MIN)
            fir_factor = dfl_pkg::FACTOR_MIN;
        else if (value > dfl_pkg::FACTOR_MAX)
            fir_factor = dfl_pkg::FACTOR_MAX;
        else
            fir_factor = value;
        fir_clear();
    endfunction

    // Push one sample; returns 1 with the decimated output when the period closes
    function automatic bit fir_filter_sample(input t_sample s, output t_sample y);
        longint acc;
        longint r;
        int     idx;
        y = '0;
        fir_hist[fir_wptr] = s;
        fir_wptr = (fir_wptr + 1) % dfl_pkg::TAPS;
        fir_phase++;
        if (fir_phase < fir_factor)
            return 1'b0;
        fir_phase = 0;
        acc = 0;
        idx = (fir_wptr + dfl_pkg::TAPS - 1) % dfl_pkg::TAPS;
        // newest sample meets tap 0
        for (int k = 0; k < dfl_pkg::TAPS; k++) begin
            acc += longint'(dfl_pkg::COEF_ROM[k]) * longint'(fir_hist[idx]);
            idx = (idx + dfl_pkg::TAPS - 1) % dfl_pkg::TAPS;
        end
        // round half up, floor, then saturate
        r = (acc + (longint'(1) << (dfl_pkg::FRAC_SHIFT - 1))) >>> dfl_pkg::FRAC_SHIFT;
        if (r > SAMP_MAX)
            r = SAMP_MAX;
        if (r < SAMP_MIN)
            r = SAMP_MIN;
        y = t_sample'(r);
        return 1'b1;
    endfunction

    function automatic void push_sample(input t_sample s);
        t_pending p;
        p.kind   = ENT_SAMPLE;
        p.factor = '0;
        p.sample = s;
        pending_q.insert(pending_q.size(), p);
    endfunction

    function automatic void push_factor(input logic [dfl_pkg::FACTOR_W-1:0] f);
        t_pending p;
        p.kind   = ENT_CFG;
        p.factor = f;
        p.sample = '0;
        pending_q.insert(pending_q.size(), p);
    endfunction

    // Idle draw, with occasional switches into and out of back-to-back stretches
    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        return burst ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("** decimating_fir_lowpass: FAILED **");
        $finish;
    end

    // Monitor: output check, factor writes to the predictor, then prediction for the accepted input beat
    always @(posedge i_clk) begin : beat_monitor
        t_sample want;
        t_sample got;
        cycle_count++;
        if (i_rst_n) begin
            if (samp_out_if.valid && samp_out_if.ready) begin
                got = samp_out_if.sample_out;
                out_taken = 1'b1;
                if (filtered_q.size() == 0) begin
                    $error("sample_out: unexpected beat, expected none, actual %0d", got);
                    fail_count++;
                end else begin
                    want = filtered_q.pop_front();
                    if (got !== want) begin
                        $error("sample_out mismatch: expected %0d, actual %0d", want, got);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
                fir_load_factor(cfg_wdata);
            if (samp_in_if.valid && samp_in_if.ready) begin
                in_taken = 1'b1;
                if (fir_filter_sample(samp_in_if.sample_in, want))
                    filtered_q.insert(filtered_q.size(), want);
            end
        end
    end

    // Driver: input beats and factor writes, then the output ready pattern
    always @(negedge i_clk) begin : beat_driver
        bit cfg_go;
        cfg_go = 1'b0;
        if (i_rst_n) begin
            if (in_taken) begin
                in_taken  = 1'b0;
                in_loaded = 1'b0;
            end
            if (!in_loaded) begin
                if (pending_q.size() != 0 && pending_q[0].kind == ENT_CFG) begin
                    // factor writes only once the filter has drained
                    if (filtered_q.size() == 0)
                        settle_count++;
                    else
                        settle_count = 0;
                    if (settle_count >= SETTLE_CYCLES) begin
                        cfg_go = 1'b1;
                        cfg_wdata <= pending_q[0].factor;
                        void'(pending_q.pop_front());
                        settle_count = 0;
                    end
                    samp_in_if.valid <= 1'b0;
                end else if (in_gap != 0) begin
                    in_gap--;
                    samp_in_if.valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    samp_in_if.sample_in <= pending_q[0].sample;
                    samp_in_if.valid     <= 1'b1;
                    void'(pending_q.pop_front());
                    in_loaded = 1'b1;
                    in_gap    = draw_gap(in_burst);
                end else begin
                    samp_in_if.valid <= 1'b0;
                end
            end

            if (out_taken) begin
                out_taken = 1'b0;
                out_gap   = draw_gap(out_burst);
            end
            if (out_gap != 0) begin
                out_gap--;
                samp_out_if.ready <= 1'b0;
            end else begin
                samp_out_if.ready <= 1'b1;
            end
        end
        cfg_we <= cfg_go;
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        t_stim_mode                   mode;
        logic [dfl_pkg::FACTOR_W-1:0] f;
        int                           n_random;
        int                           len;
        int                           amp;
        bit                           neg;
        t_sample                      dc;
        t_sample                      s;

        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        samp_in_if.valid     = 1'b0;
        samp_in_if.sample_in = '0;
        samp_out_if.ready    = 1'b0;
        cycle_count          = 0;
        fail_count           = 0;
        in_taken             = 1'b0;
        in_loaded            = 1'b0;
        out_taken            = 1'b0;
        in_burst             = 1'b0;
        out_burst            = 1'b0;
        in_gap               = 0;
        out_gap              = 0;
        settle_count         = 0;
        fir_factor           = dfl_pkg::FACTOR_RESET;
        fir_clear();

        // Directed: reset factor, full-scale and bit patterns
        repeat (6) push_sample(t_sample'(SAMP_MAX));
        repeat (6) push_sample(t_sample'(SAMP_MIN));
        push_sample(16'sh0001);
        push_sample(16'shFFFF);
        push_sample(16'sh5555);
        push_sample(16'shAAAA);
        push_sample(16'sh0000);
        push_sample(16'sh7FFF);
        // zero factor behaves as one
        push_factor(5'd0);
        push_sample(t_sample'(SAMP_MAX));
        push_sample(t_sample'(SAMP_MIN));
        push_sample(16'sh0001);
        // above-range factor saturates to 16
        push_factor(5'd31);
        push_sample(16'sh8000);
        push_sample(16'sh7FFF);
        push_factor(5'd17);
        push_sample(16'sh1234);
        push_factor(5'd16);
        push_sample(16'shEDCB);

        // Random phases, each under a fresh factor
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            mode = t_stim_mode'($urandom_range(0, 4));
            case ($urandom_range(0, 6))
                0: f = 5'd1;
                1: f = 5'd16;
                2: f = 5'd0;
                3: f = 5'd31;
                default: f = dfl_pkg::FACTOR_W'($urandom_range(0, 31));
            endcase
            // sign-aligned runs need an output on every sample
            if (mode == MODE_ALIGNED)
                f = dfl_pkg::FACTOR_W'($urandom_range(0, 1));
            push_factor(f);
            if (mode == MODE_ALIGNED) begin
                len = 0;
                repeat ($urandom_range(1, 3)) begin
                    amp = $urandom_range(16384, 32768);
                    neg = 1'($urandom_range(0, 1));
                    for (int k = 0; k < dfl_pkg::TAPS; k++) begin
                        if ((dfl_pkg::COEF_ROM[k] < 0) != neg)
                            s = (amp > SAMP_MAX) ? t_sample'(SAMP_MIN) : t_sample'(-amp);
                        else
                            s = (amp > SAMP_MAX) ? t_sample'(SAMP_MAX) : t_sample'(amp);
                        push_sample(s);
                    end
                    len += dfl_pkg::TAPS;
                end
            end else begin
                len = $urandom_range(16, 120);
                dc  = t_sample'($urandom_range(0, 65535));
                for (int i = 0; i < len; i++) begin
                    case (mode)
                        MODE_EXTREME: begin
                            case ($urandom_range(0, 4))
                                0: s = t_sample'(SAMP_MAX);
                                1: s = t_sample'(SAMP_MIN);
                                2: s = 16'sh0000;
                                3: s = 16'shFFFF;
                                default: s = 16'sh0001;
                            endcase
                        end
                        MODE_DC:    s = ($urandom_range(0, 15) == 0) ? -dc : dc;
                        MODE_SMALL: s = t_sample'(int'($urandom_range(0, 127)) - 64);
                        default:    s = t_sample'($urandom_range(0, 65535));
                    endcase
                    push_sample(s);
                end
            end
            n_random += len;
        end

        // Reset, released on a falling edge
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: everything accepted and every output seen, then a quiet tail
        @(posedge i_clk);
        while (pending_q.size() != 0 || samp_in_if.valid || filtered_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (filtered_q.size() != 0)
            $error("sample_out: %0d expected beats never arrived", filtered_q.size());
        if (fail_count == 0 && filtered_q.size() == 0) begin
            $display("** decimating_fir_lowpass: PASSED **");
        end else begin
            $display("** decimating_fir_lowpass: FAILED **");
        end
        $finish;
    end

endmodule
